// ----- src/bcm_pkg.sv -----
// Shared types, constellation tables and mode helpers for the bit to constellation mapper.
`timescale 1ns / 1ps

package bcm_pkg;

	localparam int MAX_BITS_PER_SYMBOL = 4;
	localparam int BPS_CAP = (MAX_BITS_PER_SYMBOL < 1) ? 1 :
		((MAX_BITS_PER_SYMBOL > 4) ? 4 : MAX_BITS_PER_SYMBOL);

	localparam logic [63:0] SYMBOL_ORDER_RESET = 64'hFEDC_BA98_7654_3210;

	typedef enum logic [2:0] {
		MODE_BPSK   = 3'd0,
		MODE_OBPSK  = 3'd1,
		MODE_QPSK   = 3'd2,
		MODE_PSK8   = 3'd3,
		MODE_PAM4   = 3'd4,
		MODE_QAM16  = 3'd5
	} mode_t;

	typedef enum logic {
		CFG_MODE  = 1'b0,
		CFG_ORDER = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic signed [15:0] i;
		logic signed [15:0] q;
	} point_t;

	typedef struct packed {
		logic       emit;
		logic       bad;
		logic       last;
		logic [3:0] sym;
	} gather_t;

	localparam logic signed [15:0] PC  = 16'sd15137;
	localparam logic signed [15:0] PS  = 16'sd6270;
	localparam logic signed [15:0] A3  = 16'sd21981;
	localparam logic signed [15:0] A1  = 16'sd7327;
	localparam logic signed [15:0] L3  = 16'sd15543;
	localparam logic signed [15:0] L1  = 16'sd5181;
	localparam logic signed [15:0] ONE = 16'sd16384;
	localparam logic signed [15:0] ZRO = 16'sd0;

	localparam point_t POINTS [36] = '{
		'{ONE, ZRO}, '{-ONE, ZRO},
		'{ZRO, ONE}, '{ZRO, -ONE},
		'{ZRO, -ONE}, '{ONE, ZRO}, '{-ONE, ZRO}, '{ZRO, ONE},
		'{PC, PS}, '{-PC, PS}, '{-PC, -PS}, '{PC, -PS},
		'{-PS, -PC}, '{PS, -PC}, '{PS, PC}, '{-PS, PC},
		'{-A3, ZRO}, '{-A1, ZRO}, '{A3, ZRO}, '{A1, ZRO},
		'{L3, -L3}, '{-L1, -L3}, '{L3, L1}, '{-L1, L1},
		'{-L3, -L3}, '{L1, -L3}, '{-L3, L1}, '{L1, L1},
		'{-L1, -L1}, '{L3, -L1}, '{-L1, L3}, '{L3, L3},
		'{L1, -L1}, '{-L3, -L1}, '{L1, L3}, '{-L3, L3}
	};

	function automatic logic [2:0] mode_bits(input logic [2:0] m);
		logic [2:0] b;
		unique case (m)
			MODE_QPSK:  b = 3'd2;
			MODE_PSK8:  b = 3'd3;
			MODE_PAM4:  b = 3'd2;
			MODE_QAM16: b = 3'd4;
			default:    b = 3'd1;
		endcase
		if (b > 3'(BPS_CAP)) begin
			b = 3'(BPS_CAP);
		end
		return b;
	endfunction

	function automatic logic [4:0] table_base(input logic [2:0] m);
		logic [4:0] b;
		unique case (m)
			MODE_OBPSK: b = 5'd2;
			MODE_QPSK:  b = 5'd4;
			MODE_PSK8:  b = 5'd8;
			MODE_PAM4:  b = 5'd16;
			MODE_QAM16: b = 5'd20;
			default:    b = 5'd0;
		endcase
		return b;
	endfunction

	function automatic logic [3:0] table_mask(input logic [2:0] m);
		logic [3:0] k;
		unique case (m)
			MODE_QPSK:  k = 4'd3;
			MODE_PSK8:  k = 4'd7;
			MODE_PAM4:  k = 4'd3;
			MODE_QAM16: k = 4'd15;
			default:    k = 4'd1;
		endcase
		return k;
	endfunction

endpackage

// ----- src/bcm_gather.sv -----
// Bit gathering state: collects bits into symbol values and tracks aborted packets.
`timescale 1ns / 1ps

module bcm_gather (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [7:0]        bit_in,
	input  logic              last_in,
	input  logic [2:0]        mode,
	output bcm_pkg::gather_t  gather
);
	import bcm_pkg::*;

	logic [3:0] acc_q;
	logic [1:0] cnt_q;
	logic       drop_q;

	logic [3:0] acc_n;
	logic [2:0] n;
	logic [2:0] bps;
	logic [2:0] sh;
	logic       bad;
	logic       done;

	always_comb begin
		bps   = mode_bits(mode);
		bad   = |bit_in[7:1];
		acc_n = {acc_q[2:0], bit_in[0]};
		n     = 3'(cnt_q) + 3'd1;
		done  = (n >= bps) || last_in;
		sh    = (n < bps) ? (bps - n) : 3'd0;

		gather.emit = 1'b0;
		gather.bad  = 1'b0;
		gather.last = last_in;
		gather.sym  = 4'(acc_n << sh);
		if (!drop_q) begin
			if (bad) begin
				gather.emit = 1'b1;
				gather.bad  = 1'b1;
			end else if (done) begin
				gather.emit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= 4'd0;
			cnt_q  <= 2'd0;
			drop_q <= 1'b0;
		end else if (advance) begin
			if (drop_q) begin
				if (last_in) begin
					drop_q <= 1'b0;
				end
			end else if (bad) begin
				acc_q  <= 4'd0;
				cnt_q  <= 2'd0;
				drop_q <= !last_in;
			end else if (done) begin
				acc_q <= 4'd0;
				cnt_q <= 2'd0;
			end else begin
				acc_q <= acc_n;
				cnt_q <= n[1:0];
			end
		end
	end

endmodule

// ----- src/bcm_point_map.sv -----
// Symbol reordering and constellation point lookup.
`timescale 1ns / 1ps

module bcm_point_map (
	input  logic              [2:0]  mode,
	input  logic              [63:0] symbol_order,
	input  bcm_pkg::gather_t         gather,
	output logic signed       [15:0] i_val,
	output logic signed       [15:0] q_val
);
	import bcm_pkg::*;

	logic [3:0] entry;
	logic [5:0] idx;
	point_t     pt;

	always_comb begin
		entry = symbol_order[4 * gather.sym +: 4] & table_mask(mode);
		idx   = 6'(table_base(mode)) + 6'(entry);
		pt    = POINTS[idx];
		if (gather.bad) begin
			i_val = 16'sd0;
			q_val = 16'sd0;
		end else begin
			i_val = pt.i;
			q_val = pt.q;
		end
	end

endmodule

// ----- src/bit_to_constellation_mapper_unit.sv -----
// Top level of the bit to constellation mapper: input register, configuration and result register.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | in_valid, in_ready, bit_value, last   | in
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//  output  | out_valid, out_ready, i_out, q_out, last_symbol, bad_bit | out
//
// One bit beat is accepted every cycle while the output is not stalled; a symbol's final bit beat
// passes the input register and then the result register, with the point lookup between, before the symbol leaves.
// Reset clears the gathered bits, the drop flag and both valid flags, and restores the
// configuration registers to their reset values.
// A stalled output holds the result register; the input register then fills and in_ready drops.
`timescale 1ns / 1ps

module bit_to_constellation_mapper_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic        [7:0]  bit_value,
	input  logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic        [63:0] cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] i_out,
	output logic signed [15:0] q_out,
	output logic               last_symbol,
	output logic               bad_bit
);
	import bcm_pkg::*;

	logic        valid_s1;
	logic [7:0]  bit_s1;
	logic        last_s1;
	logic        advance;

	logic [2:0]  mode_q;
	logic [63:0] order_q;

	logic        out_valid_q;
	logic signed [15:0] i_q;
	logic signed [15:0] q_q;
	logic        last_q;
	logic        bad_q;

	gather_t     gather;
	logic signed [15:0] i_val;
	logic signed [15:0] q_val;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BPSK;
			order_q <= SYMBOL_ORDER_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MODE:  mode_q  <= cfg_data[2:0];
				CFG_ORDER: order_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bit_s1  <= bit_value;
			last_s1 <= last;
		end
	end

	bcm_gather u_gather (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.bit_in  (bit_s1),
		.last_in (last_s1),
		.mode    (mode_q),
		.gather  (gather)
	);

	bcm_point_map u_point_map (
		.mode         (mode_q),
		.symbol_order (order_q),
		.gather       (gather),
		.i_val        (i_val),
		.q_val        (q_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && gather.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && gather.emit) begin
			i_q    <= i_val;
			q_q    <= q_val;
			last_q <= gather.last;
			bad_q  <= gather.bad;
		end
	end

	assign out_valid   = out_valid_q;
	assign i_out       = i_q;
	assign q_out       = q_q;
	assign last_symbol = last_q;
	assign bad_bit     = bad_q;

endmodule

// ----- dv/bit_to_constellation_mapper_unit_tb.sv -----
// Self-checking testbench for the bit to constellation mapper: packets in, predicted I/Q points out.
`timescale 1ns / 1ps

module bit_to_constellation_mapper_unit_tb;
	import bcm_pkg::*;

	localparam logic [2:0] MODE_SPARE = 3'd7;
	localparam logic [63:0] ORDER_AT_RESET = 64'hFEDC_BA98_7654_3210;

	localparam logic signed [15:0] UNIT = 16'sd16384;
	localparam logic signed [15:0] P8_C = 16'sd15137;
	localparam logic signed [15:0] P8_S = 16'sd6270;
	localparam logic signed [15:0] PAM_O = 16'sd21981;
	localparam logic signed [15:0] PAM_N = 16'sd7327;
	localparam logic signed [15:0] QAM_O = 16'sd15543;
	localparam logic signed [15:0] QAM_N = 16'sd5181;

	localparam logic signed [15:0] PSK8_I [8] = '{P8_C, -P8_C, -P8_C, P8_C,
		-P8_S, P8_S, P8_S, -P8_S};
	localparam logic signed [15:0] PSK8_Q [8] = '{P8_S, P8_S, -P8_S, -P8_S,
		-P8_C, -P8_C, P8_C, P8_C};
	localparam logic signed [15:0] PAM4_I [4] = '{-PAM_O, -PAM_N, PAM_O, PAM_N};
	localparam logic signed [15:0] QAM16_I [16] = '{QAM_O, -QAM_N, QAM_O, -QAM_N,
		-QAM_O, QAM_N, -QAM_O, QAM_N, -QAM_N, QAM_O, -QAM_N, QAM_O,
		QAM_N, -QAM_O, QAM_N, -QAM_O};
	localparam logic signed [15:0] QAM16_Q [16] = '{-QAM_O, -QAM_O, QAM_N, QAM_N,
		-QAM_O, -QAM_O, QAM_N, QAM_N, -QAM_N, -QAM_N, QAM_O, QAM_O,
		-QAM_N, -QAM_N, QAM_O, QAM_O};

	typedef struct packed {
		logic [7:0] value;
		logic       fin;
	} bit_beat_t;

	typedef struct packed {
		logic signed [15:0] i;
		logic signed [15:0] q;
		logic               fin;
		logic               bad;
	} mapped_point_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic        [7:0]  bit_value = 8'd0;
	logic               last = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	cfg_index_t         cfg_index = CFG_MODE;
	logic        [63:0] cfg_data = 64'd0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] i_out;
	logic signed [15:0] q_out;
	logic               last_symbol;
	logic               bad_bit;

	bit_beat_t     beats_to_send[$];
	mapped_point_t expected_points[$];
	bit_beat_t     next_beat;
	mapped_point_t due;

	logic [2:0]  cur_mode = MODE_BPSK;
	logic [63:0] cur_order = ORDER_AT_RESET;
	logic [3:0]  gathered = 4'd0;
	logic [1:0]  gathered_count = 2'd0;
	logic        dropping = 1'b0;

	int send_gap_pct = 0;
	int stall_pct = 0;
	int sent_beats = 0;
	int mismatches = 0;

	bit_to_constellation_mapper_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.bit_value  (bit_value),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.i_out      (i_out),
		.q_out      (q_out),
		.last_symbol(last_symbol),
		.bad_bit    (bad_bit)
	);

	always #4 clk = ~clk;

	function automatic logic [2:0] bits_for_mode(input logic [2:0] m);
		logic [2:0] b;
		case (m)
			MODE_QPSK:  b = 3'd2;
			MODE_PSK8:  b = 3'd3;
			MODE_PAM4:  b = 3'd2;
			MODE_QAM16: b = 3'd4;
			default:    b = 3'd1;
		endcase
		if (b > 3'(MAX_BITS_PER_SYMBOL)) begin
			b = 3'(MAX_BITS_PER_SYMBOL);
		end
		return b;
	endfunction

	// The table entry is cut down to the constellation size by indexing with its low bits.
	function automatic mapped_point_t point_for(input logic [2:0] m, input logic [3:0] e);
		mapped_point_t p;
		p = '0;
		case (m)
			MODE_OBPSK: p.q = e[0] ? -UNIT : UNIT;
			MODE_QPSK: begin
				case (e[1:0])
					2'd0: p.q = -UNIT;
					2'd1: p.i = UNIT;
					2'd2: p.i = -UNIT;
					default: p.q = UNIT;
				endcase
			end
			MODE_PSK8: begin
				p.i = PSK8_I[e[2:0]];
				p.q = PSK8_Q[e[2:0]];
			end
			MODE_PAM4:  p.i = PAM4_I[e[1:0]];
			MODE_QAM16: begin
				p.i = QAM16_I[e];
				p.q = QAM16_Q[e];
			end
			default:    p.i = e[0] ? -UNIT : UNIT;
		endcase
		return p;
	endfunction

	task automatic predict_beat(input logic [7:0] b, input logic l);
		logic [3:0] acc;
		logic [2:0] n;
		logic [2:0] bps;
		logic [2:0] sh;
		logic [3:0] sym;
		mapped_point_t p;
		if (dropping) begin
			if (l) begin
				dropping = 1'b0;
			end
			return;
		end
		if (b > 8'd1) begin
			gathered = 4'd0;
			gathered_count = 2'd0;
			dropping = !l;
			p = '0;
			p.fin = l;
			p.bad = 1'b1;
			expected_points = {expected_points, p};
			return;
		end
		bps = bits_for_mode(cur_mode);
		acc = {gathered[2:0], b[0]};
		n = {1'b0, gathered_count} + 3'd1;
		if (n >= bps || l) begin
			sh = (n < bps) ? bps - n : 3'd0;
			sym = 4'(acc << sh);
			p = point_for(cur_mode, cur_order[4 * sym +: 4]);
			p.fin = l;
			p.bad = 1'b0;
			expected_points = {expected_points, p};
			gathered = 4'd0;
			gathered_count = 2'd0;
		end else begin
			gathered = acc;
			gathered_count = n[1:0];
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_beat(bit_value, last);
			end
			if (!in_valid || in_ready) begin
				if (beats_to_send.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
					next_beat = beats_to_send.pop_front();
					in_valid <= 1'b1;
					bit_value <= next_beat.value;
					last <= next_beat.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					$error("unexpected beat: i_out %0d q_out %0d last_symbol %0b bad_bit %0b",
						i_out, q_out, last_symbol, bad_bit);
					mismatches++;
				end else begin
					due = expected_points.pop_front();
					if (i_out !== due.i) begin
						$error("i_out: expected %0d, got %0d", due.i, i_out);
						mismatches++;
					end
					if (q_out !== due.q) begin
						$error("q_out: expected %0d, got %0d", due.q, q_out);
						mismatches++;
					end
					if (last_symbol !== due.fin) begin
						$error("last_symbol: expected %0b, got %0b", due.fin, last_symbol);
						mismatches++;
					end
					if (bad_bit !== due.bad) begin
						$error("bad_bit: expected %0b, got %0b", due.bad, bad_bit);
						mismatches++;
					end
				end
			end
			out_ready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	task automatic queue_beat(input logic [7:0] v, input logic l);
		bit_beat_t bb;
		bb.value = v;
		bb.fin = l;
		beats_to_send = {beats_to_send, bb};
	endtask

	// Holds the sender until every predicted point has come out, then lets the pipeline empty.
	task automatic settle();
		while (beats_to_send.size() != 0 || in_valid || expected_points.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_MODE) begin
			cur_mode = val[2:0];
		end else begin
			cur_order = val;
		end
	endtask

	// Bits after a bad byte are still sent; the block drops them until the packet ends.
	task automatic send_packet(input bit closed);
		int len;
		int bad_pct;
		bit aborted;
		logic [7:0] v;
		len = $urandom_range(24, 1);
		bad_pct = ($urandom_range(99, 0) < 5) ? 40 : 2;
		aborted = 1'b0;
		for (int k = 0; k < len; k++) begin
			if (aborted) begin
				v = 8'($urandom);
			end else if ($urandom_range(99, 0) < bad_pct) begin
				v = 8'($urandom_range(255, 2));
			end else begin
				v = 8'($urandom_range(1, 0));
			end
			queue_beat(v, closed && k == len - 1);
			sent_beats++;
			if (v > 8'd1) begin
				aborted = 1'b1;
			end
		end
	endtask

	initial begin
		logic [2:0]  mode_pick;
		logic [63:0] order_pick;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_beat(8'h00, 1'b0);
		queue_beat(8'h01, 1'b1);
		queue_beat(8'hFF, 1'b0);
		queue_beat(8'h01, 1'b0);
		queue_beat(8'h00, 1'b1);
		queue_beat(8'h02, 1'b1);
		settle();
		write_reg(CFG_MODE, 64'(MODE_QAM16));
		queue_beat(8'h01, 1'b0);
		queue_beat(8'h00, 1'b0);
		queue_beat(8'h01, 1'b0);
		queue_beat(8'h01, 1'b0);
		queue_beat(8'h01, 1'b0);
		queue_beat(8'h01, 1'b1);
		queue_beat(8'h01, 1'b0);
		queue_beat(8'h00, 1'b0);
		queue_beat(8'h01, 1'b0);
		settle();
		// Three bits are held; the narrower mode emits them on the next beat.
		write_reg(CFG_MODE, 64'(MODE_QPSK));
		queue_beat(8'h01, 1'b0);
		queue_beat(8'h00, 1'b1);
		settle();
		write_reg(CFG_MODE, 64'(MODE_PSK8));
		queue_beat(8'h01, 1'b0);
		queue_beat(8'h01, 1'b0);
		queue_beat(8'h01, 1'b0);
		queue_beat(8'h00, 1'b0);
		queue_beat(8'h01, 1'b1);
		settle();
		write_reg(CFG_MODE, 64'(MODE_PAM4));
		queue_beat(8'h01, 1'b0);
		queue_beat(8'h00, 1'b0);
		settle();
		write_reg(CFG_MODE, 64'(MODE_OBPSK));
		queue_beat(8'h00, 1'b0);
		queue_beat(8'h01, 1'b1);
		settle();
		write_reg(CFG_MODE, 64'(MODE_SPARE));
		queue_beat(8'h01, 1'b1);
		settle();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin
					send_gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_gap_pct = 47;
					stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					stall_pct = 47;
				end
				default: begin
					send_gap_pct = 24;
					stall_pct = 24;
				end
			endcase
			case (ph % 5)
				0: order_pick = 64'd0;
				1: order_pick = '1;
				2: order_pick = ORDER_AT_RESET;
				3: order_pick = 64'h0123_4567_89AB_CDEF;
				default: order_pick = {$urandom, $urandom};
			endcase
			mode_pick = (ph < 8) ? 3'(ph) : 3'($urandom_range(7, 0));
			write_reg(CFG_MODE, 64'(mode_pick));
			write_reg(CFG_ORDER, order_pick);
			sent_beats = 0;
			while (sent_beats < 58) begin
				send_packet(1'b1);
			end
			settle();
			while (sent_beats < 116) begin
				send_packet(1'b1);
			end
			// A partial symbol that may be left open here carries into the next mode setting.
			if ($urandom_range(1, 0) == 1) begin
				repeat ($urandom_range(3, 1)) queue_beat(8'($urandom_range(1, 0)), 1'b0);
			end
			settle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("bit_to_constellation_mapper_unit_tb: clean");
		end else begin
			$display("bit_to_constellation_mapper_unit_tb: errors");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("bit_to_constellation_mapper_unit_tb: errors");
		$finish;
	end

endmodule
